>>> sv/ivcp_pkg.sv
// Package for the interleaved VLC codeword parser: field widths, payload types and
// the reset value of the start code threshold. No dependencies.
`default_nettype none
package ivcp_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 6;
   localparam int INFO_W     = 31;
   localparam int SYM_IDX_W  = 11;
   localparam logic [LEN_W-1:0] START_CODE_MIN_RESET = 6'd31;

   typedef logic [BYTE_W-1:0] byte_type;

   // One decoded codeword. The last_of_byte mark is added at the output stage.
   typedef struct packed {
      logic [LEN_W-1:0]     code_length;
      logic [INFO_W-1:0]    info_word;
      logic                 is_start_code;
      logic                 end_of_sequence;
      logic                 code_too_long;
      logic                 slice_overflow;
      logic [SYM_IDX_W-1:0] symbol_index;
   } code_type;

   // Hand-off from the front queue to the bit engine.
   typedef struct packed {
      logic     valid;
      byte_type data;
   } queue_head_type;

endpackage
`default_nettype wire

>>> sv/ivcp_channels.sv
// Valid/ready channel interfaces for stream bytes and decoded codewords.
// Depends on ivcp_pkg.
`default_nettype none
interface ivcp_req_if import ivcp_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ivcp_rsp_if import ivcp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LEN_W-1:0]     code_length;
   logic [INFO_W-1:0]    info_word;
   logic                 is_start_code;
   logic                 end_of_sequence;
   logic                 code_too_long;
   logic                 slice_overflow;
   logic [SYM_IDX_W-1:0] symbol_index;
   logic                 last_of_byte;

   modport source (output valid, output code_length, output info_word,
                   output is_start_code, output end_of_sequence, output code_too_long,
                   output slice_overflow, output symbol_index, output last_of_byte,
                   input ready);
   modport sink   (input valid, input code_length, input info_word,
                   input is_start_code, input end_of_sequence, input code_too_long,
                   input slice_overflow, input symbol_index, input last_of_byte,
                   output ready);
endinterface
`default_nettype wire

>>> sv/ivcp_front.sv
// Front end of the parser: accepts stream bytes into a two-entry queue.
// Depends on ivcp_pkg and ivcp_channels.
`default_nettype none
module ivcp_front import ivcp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ivcp_req_if.sink    req_if,
   output queue_head_type head,
   input  wire logic   pop
);

   byte_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push;

   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign head.valid   = (count_ff != 2'd0);
   assign head.data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_if.stream_byte;
      end
   end

endmodule
`default_nettype wire

>>> sv/ivcp_back.sv
// Back end: walks each byte one bit per cycle unless stalled, builds codewords and
// delivers them via a hold stage and output register. Depends on ivcp_pkg, ivcp_channels.
`default_nettype none
module ivcp_back import ivcp_pkg::*; #(
   parameter int MAX_CODE_LEN = 63,
   parameter int MAX_SYMBOLS  = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [LEN_W-1:0] start_code_min_length,
   input  wire queue_head_type   head,
   output logic                  pop,
   ivcp_rsp_if.source            rsp_if
);

   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int IDX_W = (CNT_W > SYM_IDX_W) ? CNT_W : SYM_IDX_W;
   localparam logic [CNT_W-1:0] MAX_SYM_C = CNT_W'(MAX_SYMBOLS);
   localparam logic [LEN_W:0]   MAX_LEN_C = (LEN_W+1)'(MAX_CODE_LEN);

   // Bit engine state.
   byte_type          shift_ff,  shift_in;
   logic [2:0]        bit_cnt_ff, bit_cnt_in;
   logic              busy_ff,   busy_in;
   logic              expect_ff, expect_in;
   logic [LEN_W-1:0]  plen_ff,   plen_in;
   logic [INFO_W-1:0] pinfo_ff,  pinfo_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              seq_end_ff, seq_end_in;

   // Hold stage and output register.
   logic              hold_valid_ff, hold_valid_in;
   logic              hold_done_ff,  hold_done_in;
   code_type          hold_ff,       hold_in;
   logic              out_valid_ff,  out_valid_in;
   code_type          out_ff,        out_in;
   logic              out_last_ff,   out_last_in;

   // Per-bit decisions.
   logic              bit_v;
   logic [LEN_W-1:0]  len1;
   logic              gen;
   code_type          gen_res;
   logic              eos_now;
   logic              p_expect;
   logic [LEN_W-1:0]  p_plen;
   logic [INFO_W-1:0] p_pinfo;
   logic [CNT_W-1:0]  p_count;
   logic              p_seq_end;
   logic [IDX_W-1:0]  idx_wide;

   logic              out_free;
   logic              step;
   logic              byte_end;
   logic              hold_move;
   logic              seq_after;

   always_comb begin
      bit_v     = shift_ff[BYTE_W-1];
      len1      = plen_ff + 6'd1;
      gen       = 1'b0;
      gen_res   = '0;
      eos_now   = 1'b0;
      p_expect  = expect_ff;
      p_plen    = plen_ff;
      p_pinfo   = pinfo_ff;
      p_count   = count_ff;
      p_seq_end = seq_end_ff;
      idx_wide  = IDX_W'(count_ff);
      if (expect_ff) begin
         p_pinfo  = {pinfo_ff[INFO_W-2:0], bit_v};
         p_plen   = len1;
         p_expect = 1'b0;
      end else if (!bit_v) begin
         if (({1'b0, len1} + 7'd2) > MAX_LEN_C) begin
            gen                   = 1'b1;
            gen_res.code_too_long = 1'b1;
            p_plen                = '0;
            p_pinfo               = '0;
         end else begin
            p_plen   = len1;
            p_expect = 1'b1;
         end
      end else begin
         gen                 = 1'b1;
         gen_res.code_length = len1;
         gen_res.info_word   = pinfo_ff;
         p_plen              = '0;
         p_pinfo             = '0;
         if (len1 >= start_code_min_length) begin
            // A start code opens a new slice, or ends the sequence if its info LSB is set.
            gen_res.is_start_code   = 1'b1;
            gen_res.end_of_sequence = pinfo_ff[0];
            eos_now                 = pinfo_ff[0];
            p_count                 = pinfo_ff[0] ? '0 : CNT_W'(1);
            p_seq_end               = pinfo_ff[0];
         end else begin
            if (count_ff >= MAX_SYM_C) begin
               gen_res.slice_overflow = 1'b1;
               p_count                = MAX_SYM_C;
               idx_wide               = IDX_W'(MAX_SYM_C);
            end else begin
               p_count = count_ff + CNT_W'(1);
            end
            gen_res.symbol_index = idx_wide[SYM_IDX_W-1:0];
         end
      end
   end

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign step      = busy_ff && !(gen && hold_valid_ff && !out_free);
   assign byte_end  = busy_ff && ((bit_cnt_ff == 3'd7) || eos_now);
   assign pop       = head.valid && (!busy_ff || (step && byte_end));
   assign hold_move = hold_valid_ff && out_free && (hold_done_ff || (busy_ff && gen));
   assign seq_after = step ? p_seq_end : seq_end_ff;

   always_comb begin
      shift_in   = step ? {shift_ff[BYTE_W-2:0], 1'b0} : shift_ff;
      bit_cnt_in = step ? bit_cnt_ff + 3'd1 : bit_cnt_ff;
      busy_in    = busy_ff;
      if (pop) begin
         shift_in   = head.data;
         bit_cnt_in = 3'd0;
         busy_in    = !seq_after;
      end else if (step && byte_end) begin
         busy_in = 1'b0;
      end
      expect_in  = step ? p_expect : expect_ff;
      plen_in    = step ? p_plen : plen_ff;
      pinfo_in   = step ? p_pinfo : pinfo_ff;
      count_in   = step ? p_count : count_ff;
      seq_end_in = seq_after;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_done_in  = hold_done_ff;
      hold_in       = hold_ff;
      if (step && gen) begin
         hold_valid_in = 1'b1;
         hold_done_in  = byte_end;
         hold_in       = gen_res;
      end else if (hold_move) begin
         hold_valid_in = 1'b0;
         hold_done_in  = 1'b0;
      end else if (step && byte_end && hold_valid_ff) begin
         hold_done_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      if (hold_move) begin
         out_valid_in = 1'b1;
         out_in       = hold_ff;
         out_last_in  = hold_done_ff;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         bit_cnt_ff    <= 3'd0;
         expect_ff     <= 1'b0;
         plen_ff       <= '0;
         pinfo_ff      <= '0;
         count_ff      <= '0;
         seq_end_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_done_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         bit_cnt_ff    <= bit_cnt_in;
         expect_ff     <= expect_in;
         plen_ff       <= plen_in;
         pinfo_ff      <= pinfo_in;
         count_ff      <= count_in;
         seq_end_ff    <= seq_end_in;
         hold_valid_ff <= hold_valid_in;
         hold_done_ff  <= hold_done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.code_length     = out_ff.code_length;
   assign rsp_if.info_word       = out_ff.info_word;
   assign rsp_if.is_start_code   = out_ff.is_start_code;
   assign rsp_if.end_of_sequence = out_ff.end_of_sequence;
   assign rsp_if.code_too_long   = out_ff.code_too_long;
   assign rsp_if.slice_overflow  = out_ff.slice_overflow;
   assign rsp_if.symbol_index    = out_ff.symbol_index;
   assign rsp_if.last_of_byte    = out_last_ff;

endmodule
`default_nettype wire

>>> sv/interleaved_vlc_codeword_parser.sv
// Top level of the interleaved VLC codeword parser: threshold register, front queue
// and back bit engine. Depends on ivcp_pkg, ivcp_channels, ivcp_front and ivcp_back.
//
//   Channel   Direction  Handshake                     Carries
//   req_if    in         valid/ready                   stream_byte
//   rsp_if    out        valid/ready                   one decoded codeword per item
//   csr_*     in         write enable, no wait         start_code_min_length
//
// The bit engine walks one byte at a time, one bit per cycle unless stalled, and ends
// a byte early at the end of sequence. It loads the next byte as it walks the last bit;
// an idle engine loads a byte before walking it, and bytes after the end of sequence
// are dropped. A codeword waits in the hold stage until the next codeword of its byte
// completes, when it moves to the output register at once, or until the byte ends, when
// it is marked last and moves once the output register is free. Reset is synchronous
// and active high. The engine stalls only when a new codeword finds both the hold stage
// and the output register full; the two-entry queue keeps taking bytes meanwhile.
`default_nettype none
module interleaved_vlc_codeword_parser import ivcp_pkg::*; #(
   parameter int MAX_CODE_LEN = 63,
   parameter int MAX_SYMBOLS  = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [LEN_W-1:0] csr_write_data,
   ivcp_req_if.sink              req_if,
   ivcp_rsp_if.source            rsp_if
);

   // Codewords at least this long are start codes.
   logic [LEN_W-1:0] start_min_ff, start_min_in;
   queue_head_type   head;
   logic             pop;

   always_comb begin
      start_min_in = csr_write_enable ? csr_write_data : start_min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_min_ff <= START_CODE_MIN_RESET;
      end else begin
         start_min_ff <= start_min_in;
      end
   end

   // The front queue decouples byte arrival from the bit engine.
   ivcp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .head   (head),
      .pop    (pop)
   );

   // The back end decodes codewords and marks the final result of each byte.
   ivcp_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .MAX_SYMBOLS  (MAX_SYMBOLS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .start_code_min_length (start_min_ff),
      .head                  (head),
      .pop                   (pop),
      .rsp_if                (rsp_if)
   );

endmodule
`default_nettype wire

>>> tb/interleaved_vlc_codeword_parser_tb.sv
// Self-checking testbench for the interleaved VLC codeword parser: directed and random
// byte streams, a bit-level codeword predictor and a per-field result check.
// Depends on ivcp_pkg, ivcp_channels and interleaved_vlc_codeword_parser.
`timescale 1ns / 1ps
module interleaved_vlc_codeword_parser_tb;
   import ivcp_pkg::*;

   localparam int MAX_CODE_LEN = 63;
   localparam int MAX_SYMBOLS  = 1024;
   // Cycles that let the two-entry byte queue and the bit engine run dry.
   localparam int IDLE_CYCLES  = 48;
   // Far above the slowest correct run, including every receiver stall at its longest.
   localparam int CYCLE_LIMIT  = 500000;

   // Parser state as the predictor tracks it between bytes.
   typedef struct packed {
      logic                 expect_info;
      logic [LEN_W-1:0]     length;
      logic [INFO_W-1:0]    info;
      logic [SYM_IDX_W-1:0] symbols;
      logic                 ended;
   } parser_state_type;

   // One codeword as it leaves the block, including the last-of-byte mark.
   typedef struct packed {
      code_type code;
      logic     last_of_byte;
   } codeword_result_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;

   ivcp_req_if req_if ();
   ivcp_rsp_if rsp_if ();

   interleaved_vlc_codeword_parser #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_if          (req_if),
      .rsp_if          (rsp_if)
   );

   // Predictor state, the threshold it believes is loaded, and the codewords that the
   // accepted bytes have produced but the block has not delivered yet.
   parser_state_type    parser_model;
   logic [LEN_W-1:0]    start_code_threshold;
   codeword_result_type awaited_codewords[$];
   codeword_result_type oldest_codeword;
   // Bits of hand-built codewords that have not been packed into a byte yet.
   logic                pending_bits[$];
   logic                sender_steady;
   int                  mismatch_count = 0;
   int                  cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Walks one byte through the parser, most significant bit first, and returns the
   // codewords it completes together with the state that follows.
   function automatic void parse_byte(input parser_state_type from_state,
                                      input byte_type value,
                                      output parser_state_type to_state,
                                      output codeword_result_type produced[$]);
      parser_state_type    s;
      codeword_result_type r;
      logic                bit_v;
      int                  cw_len;
      s = from_state;
      produced = {};
      for (int pos = 7; pos >= 0; pos--) begin
         // After the end of sequence nothing more is parsed until reset.
         if (s.ended)
            break;
         bit_v = value[pos];
         if (s.expect_info) begin
            s.info = {s.info[INFO_W-2:0], bit_v};
            s.length = s.length + LEN_W'(1);
            s.expect_info = 1'b0;
            continue;
         end
         cw_len = int'(s.length) + 1;
         r = '0;
         if (!bit_v) begin
            // A zero control bit needs room for one more info bit and a closing bit.
            if (cw_len + 2 > MAX_CODE_LEN) begin
               r.code.code_too_long = 1'b1;
               produced.push_back(r);
               s.length = '0;
               s.info = '0;
            end else begin
               s.length = LEN_W'(cw_len);
               s.expect_info = 1'b1;
            end
            continue;
         end
         r.code.code_length = LEN_W'(cw_len);
         r.code.info_word = s.info;
         if (cw_len >= int'(start_code_threshold)) begin
            // A start code opens a new slice, or ends the sequence when its info LSB is set.
            r.code.is_start_code = 1'b1;
            r.code.end_of_sequence = s.info[0];
            s.symbols = s.info[0] ? '0 : SYM_IDX_W'(1);
            s.ended = s.info[0];
         end else if (int'(s.symbols) >= MAX_SYMBOLS) begin
            r.code.slice_overflow = 1'b1;
            r.code.symbol_index = SYM_IDX_W'(MAX_SYMBOLS);
            s.symbols = SYM_IDX_W'(MAX_SYMBOLS);
         end else begin
            r.code.symbol_index = s.symbols;
            s.symbols = s.symbols + SYM_IDX_W'(1);
         end
         produced.push_back(r);
         s.length = '0;
         s.info = '0;
      end
      if (produced.size() > 0)
         produced[produced.size()-1].last_of_byte = 1'b1;
      to_state = s;
   endfunction

   // Idle lengths for both channels: mostly none, often a few cycles, now and then long.
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   // Offers one byte and waits for the handshake. A byte that would end the sequence
   // is swapped for all zeros unless the caller allows it, because the parser ignores
   // everything after the end of sequence and only reset would bring it back.
   task automatic send_byte(input byte_type value, input logic may_end);
      parser_state_type    next_state;
      codeword_result_type produced[$];
      int                  gap;
      parse_byte(parser_model, value, next_state, produced);
      if (!may_end && produced.size() > 0 &&
          produced[produced.size()-1].code.end_of_sequence) begin
         value = '0;
         parse_byte(parser_model, value, next_state, produced);
      end
      gap = sender_steady ? 0 : random_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.stream_byte <= value;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      // The byte is in; only now does the predictor move on.
      parser_model = next_state;
      foreach (produced[i])
         awaited_codewords.push_back(produced[i]);
   endtask

   // Drops valid, waits for every outstanding codeword and then lets the block settle,
   // since trailing bytes may complete nothing and still be in flight.
   task automatic wait_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (awaited_codewords.size() != 0)
         @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Loads the start code threshold; callers make sure the block is idle first.
   task automatic write_threshold(input logic [LEN_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      start_code_threshold = value;
   endtask

   // Appends a codeword with the given number of info bits: control zero and info bit
   // pairs, first info bit most significant, then the closing control one.
   task automatic queue_codeword(input int info_bits, input logic [INFO_W-1:0] info);
      for (int i = info_bits - 1; i >= 0; i--) begin
         pending_bits.push_back(1'b0);
         pending_bits.push_back(info[i]);
      end
      pending_bits.push_back(1'b1);
   endtask

   // Brings the parser back to a codeword boundary without ending the sequence: the
   // open codeword is closed with an info LSB of zero, or pushed past the length limit.
   task automatic close_open_codeword();
      if (parser_model.expect_info) begin
         pending_bits.push_back(1'b0);
         pending_bits.push_back(1'b1);
      end else if (int'(parser_model.length) + 3 > MAX_CODE_LEN) begin
         pending_bits.push_back(1'b0);
      end else if (parser_model.length != '0) begin
         pending_bits.push_back(1'b0);
         pending_bits.push_back(1'b0);
         pending_bits.push_back(1'b1);
      end
   endtask

   // Packs queued bits into bytes and sends them. Padding with ones adds one-bit
   // codewords, which keeps the stream at a codeword boundary.
   task automatic send_queued_bits(input logic pad, input logic may_end);
      byte_type value;
      if (pad)
         while (pending_bits.size() % 8 != 0)
            pending_bits.push_back(1'b1);
      while (pending_bits.size() >= 8) begin
         for (int i = 7; i >= 0; i--)
            value[i] = pending_bits.pop_front();
         send_byte(value, may_end);
      end
   endtask

   // All ones gives eight one-bit codewords from one byte, the most a byte can cause;
   // the other patterns mix control and info bits across byte borders.
   task automatic test_byte_patterns();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
   endtask

   // With the reset threshold, a codeword one step short of it counts as a symbol and
   // one of exactly that length is a start code that restarts the symbol count.
   task automatic test_start_code_threshold();
      logic [INFO_W-1:0] info;
      close_open_codeword();
      queue_codeword((int'(start_code_threshold) - 3) / 2, INFO_W'($urandom));
      info = INFO_W'($urandom);
      info[0] = 1'b0;
      queue_codeword((int'(start_code_threshold) - 1) / 2, info);
      queue_codeword(0, '0);
      send_queued_bits(1'b1, 1'b0);
   endtask

   // A codeword that keeps its control bits at zero is dropped once it cannot close
   // within the length limit; the bit after that starts a fresh codeword.
   task automatic test_too_long();
      close_open_codeword();
      for (int i = 0; i < (MAX_CODE_LEN - 1) / 2; i++) begin
         pending_bits.push_back(1'b0);
         pending_bits.push_back(1'($urandom_range(0, 1)));
      end
      pending_bits.push_back(1'b0);
      pending_bits.push_back(1'b1);
      send_queued_bits(1'b1, 1'b0);
   endtask

   // A threshold of one makes every codeword a start code. Three is the smallest
   // threshold in normal use, where a one-info-bit codeword already opens a slice.
   task automatic test_small_threshold();
      wait_until_drained();
      write_threshold(6'd1);
      send_byte(8'hFF, 1'b0);
      wait_until_drained();
      write_threshold(6'd3);
      send_byte(8'h21, 1'b0);
   endtask

   // Mostly well-formed codewords with random info, biased toward short ones, broken
   // now and then by a random byte. Start codes keep their info LSB clear so that the
   // sequence runs on. Occasionally the sender holds off until all results are in.
   task automatic test_random_codewords(input logic [LEN_W-1:0] threshold,
                                        input int byte_count);
      logic [INFO_W-1:0] info;
      int                info_bits;
      int                pick;
      int                sent;
      wait_until_drained();
      write_threshold(threshold);
      close_open_codeword();
      sent = 0;
      while (sent < byte_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_byte(byte_type'($urandom), 1'b0);
            sent++;
         end else if (pick < 10) begin
            wait_until_drained();
         end else begin
            if (pick < 55)
               info_bits = $urandom_range(0, 3);
            else if (pick < 87)
               info_bits = $urandom_range(4, 15);
            else
               info_bits = $urandom_range(16, (MAX_CODE_LEN - 1) / 2);
            info = INFO_W'($urandom);
            if (2 * info_bits + 1 >= int'(start_code_threshold))
               info[0] = 1'b0;
            queue_codeword(info_bits, info);
            sent += pending_bits.size() / 8;
            send_queued_bits(1'b0, 1'b0);
         end
      end
      send_queued_bits(1'b1, 1'b0);
   endtask

   // Bytes dense in ones give many short symbols per byte. With the highest threshold
   // start codes are almost impossible, so the slice count climbs to its limit and
   // then stays saturated. The first stretch is sent with no gaps at all.
   task automatic test_slice_overflow();
      int sent;
      int saturated_bytes;
      wait_until_drained();
      write_threshold(6'd63);
      sent = 0;
      saturated_bytes = 0;
      while (saturated_bytes < 8) begin
         sender_steady = (sent < 48);
         send_byte(byte_type'($urandom | $urandom | $urandom), 1'b0);
         sent++;
         if (int'(parser_model.symbols) >= MAX_SYMBOLS)
            saturated_bytes++;
      end
      sender_steady = 1'b0;
   endtask

   // The longest codeword with every info bit set is a start code that ends the
   // sequence; the rest of its byte and every later byte must produce nothing.
   task automatic test_end_of_sequence();
      close_open_codeword();
      queue_codeword((MAX_CODE_LEN - 1) / 2, '1);
      send_queued_bits(1'b1, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h81, 1'b1);
   endtask

   // Result check: every delivered codeword is matched, field by field, against the
   // oldest codeword the predictor is still waiting for.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_codewords.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected codeword, expected none, actual length %0d info 0x%0h",
                     $time, rsp_if.code_length, rsp_if.info_word);
         end else begin
            oldest_codeword = awaited_codewords.pop_front();
            check_field("code_length", oldest_codeword.code.code_length,
                        rsp_if.code_length);
            check_field("info_word", oldest_codeword.code.info_word, rsp_if.info_word);
            check_field("is_start_code", oldest_codeword.code.is_start_code,
                        rsp_if.is_start_code);
            check_field("end_of_sequence", oldest_codeword.code.end_of_sequence,
                        rsp_if.end_of_sequence);
            check_field("code_too_long", oldest_codeword.code.code_too_long,
                        rsp_if.code_too_long);
            check_field("slice_overflow", oldest_codeword.code.slice_overflow,
                        rsp_if.slice_overflow);
            check_field("symbol_index", oldest_codeword.code.symbol_index,
                        rsp_if.symbol_index);
            check_field("last_of_byte", oldest_codeword.last_of_byte, rsp_if.last_of_byte);
         end
      end
   end

   // The result side takes runs of codewords and may stall in between; one run in twenty
   // is long enough to let the block stream without back-pressure for a while.
   initial begin : result_ready_driver
      int run;
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
         repeat (run) begin
            @(negedge clock);
            rsp_if.ready <= 1'b1;
         end
         stall = random_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
      end
   end

   // A run that hangs, for instance on a codeword that never arrives, ends here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("interleaved_vlc_codeword_parser_tb: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.stream_byte = '0;
      sender_steady = 1'b0;
      parser_model = '0;
      start_code_threshold = START_CODE_MIN_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset threshold.
      test_byte_patterns();
      test_start_code_threshold();
      test_too_long();
      test_small_threshold();

      // Random part over several thresholds, then the slice limit. The end of sequence
      // comes last because nothing but reset brings the parser back after it.
      test_random_codewords(6'd7, 20);
      test_random_codewords(LEN_W'($urandom_range(3, 63)), 20);
      test_random_codewords(6'd21, 20);
      test_slice_overflow();
      test_end_of_sequence();

      wait_until_drained();
      if (mismatch_count == 0)
         $display("interleaved_vlc_codeword_parser_tb: clean");
      else
         $display("interleaved_vlc_codeword_parser_tb: errors");
      $finish;
   end

endmodule

>>> files.f
sv/ivcp_pkg.sv
sv/ivcp_channels.sv
sv/ivcp_front.sv
sv/ivcp_back.sv
sv/interleaved_vlc_codeword_parser.sv
tb/interleaved_vlc_codeword_parser_tb.sv
